// File: rtl/gnca_pkg.sv
// Shared types, register indexes and constants of the grid neighbor cell addresser.
package gnca_pkg;

  localparam int unsigned MAX_CELLS_PER_AXIS = 256;
  localparam int unsigned FRACTION_BITS      = 16;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned GRID_W     = 9;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned RECIP_W    = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd16;
  localparam logic [HALF_W-1:0]  HALF_RESET  = 31'd524288;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_CELLS_X    = 4'd0,
    REG_GRID_CELLS_Y    = 4'd1,
    REG_GRID_CELLS_Z    = 4'd2,
    REG_HALF_EXTENT_X   = 4'd3,
    REG_HALF_EXTENT_Y   = 4'd4,
    REG_HALF_EXTENT_Z   = 4'd5,
    REG_RECIP_VOXEL     = 4'd6,
    REG_RECIP_SIM_SCALE = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_AXES-1:0][GRID_W-1:0] cells;
    logic [NUM_AXES-1:0][HALF_W-1:0] half;
    logic [RECIP_W-1:0]              recip_voxel;
    logic [RECIP_W-1:0]              recip_sim;
  } cfg_t;

  // One walk request: per axis the first and last neighbor offset slot (0..2 for -1..+1),
  // a flag for no cell in bounds, and the linear index of the first cell to emit.
  typedef struct packed {
    logic [NUM_AXES-1:0][1:0] lo;
    logic [NUM_AXES-1:0][1:0] hi;
    logic                     empty;
    logic [IDX_W-1:0]         start;
  } walk_req_t;

endpackage

// File: rtl/grid_neighbor_cell_addresser_unit.sv
// Top level of the grid neighbor cell addresser: stream ports, configuration port, datapath.
//
// Each request carries a signed Q16.16 position and a kind. A kind 0 request yields the
// row-major indices x*NY*NZ + y*NZ + z of every in-bounds cell among the 27 cells around the
// position's cell (x outer, then y, then z inner), one result per cycle while the output is
// ready, the last one flagged on tlast; if none is in bounds a single result with in_bounds
// low is sent. A kind 1 request first scales the position by recip_sim_scale and yields its
// home cell as one result, with in_bounds low (and index 0) when that cell lies outside the
// grid. Cell coordinates come from trunc((p + half_extent) * recip_voxel_size) per axis. A
// request passes through the coordinate pipeline, the walker's request register and the
// result register before its first result is offered. Requests enter back to back unless
// stalled; the single neighbor walker then sets the sustained rate: a request holds it until
// all its results, 1 to 27, are out, and a waiting one loads as the last is issued, so its
// first result follows in the very next cycle if the output is not stalled. Configuration
// writes are always accepted and must be issued only while no request is in flight.
module grid_neighbor_cell_addresser_unit #(
  parameter int unsigned MAX_CELLS_PER_AXIS = gnca_pkg::MAX_CELLS_PER_AXIS,
  parameter int unsigned FRACTION_BITS      = gnca_pkg::FRACTION_BITS
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // Request stream.
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // tdata from bit 0 up: pos_x[31:0], pos_y[63:32], pos_z[95:64]
  input  logic [gnca_pkg::NUM_AXES*gnca_pkg::POS_W-1:0]  s_axis_tdata,
  // tuser: kind (0 neighbor query, 1 home-cell query)
  input  logic                                           s_axis_tuser,
  // Result stream.
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // tdata from bit 0 up: cell_index[23:0]
  output logic [gnca_pkg::IDX_W-1:0]                     m_axis_tdata,
  // tuser: in_bounds
  output logic                                           m_axis_tuser,
  // tlast: last_of_run
  output logic                                           m_axis_tlast,
  // Configuration writes.
  input  logic                                           cfg_valid_i,
  output logic                                           cfg_ready_o,
  input  logic [gnca_pkg::CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [gnca_pkg::CFG_DATA_W-1:0]                cfg_data_i
);

  localparam int unsigned NW  = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int unsigned NNW = 2 * NW;

  gnca_pkg::cfg_t                          cfg;
  logic [gnca_pkg::NUM_AXES-1:0][NW-1:0]   cells_eff;
  logic [NNW-1:0]                          nynz;
  logic                                    req_valid;
  logic                                    req_ready;
  gnca_pkg::walk_req_t                     req;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  gnca_cfg_regs #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .cells_eff_o(cells_eff),
    .nynz_o     (nynz)
  );

  // Position to cell coordinates, neighbor ranges and the first cell's index.
  gnca_coord_pipe #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_coord_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_pos_i   (s_axis_tdata),
    .cfg_i      (cfg),
    .cells_eff_i(cells_eff),
    .nynz_i     (nynz),
    .out_valid_o(req_valid),
    .out_ready_i(req_ready),
    .out_req_o  (req)
  );

  // Walks the in-bounds neighbor cells and drives the result register.
  gnca_nbr_walker #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_nbr_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .nz_i           (cells_eff[2]),
    .nynz_i         (nynz),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_index_o    (m_axis_tdata),
    .out_in_bounds_o(m_axis_tuser),
    .out_last_o     (m_axis_tlast)
  );

endmodule

// File: rtl/gnca_cfg_regs.sv
// Configuration register file with clamped grid sizes and the registered y-z plane size.
module gnca_cfg_regs #(
  parameter int unsigned MAX_CELLS_PER_AXIS = gnca_pkg::MAX_CELLS_PER_AXIS,
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned NNW = 2 * NW
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        wr_valid_i,
  input  logic [gnca_pkg::CFG_IDX_W-1:0]              wr_index_i,
  input  logic [gnca_pkg::CFG_DATA_W-1:0]             wr_data_i,
  output gnca_pkg::cfg_t                              cfg_o,
  output logic [gnca_pkg::NUM_AXES-1:0][NW-1:0]       cells_eff_o,
  output logic [NNW-1:0]                              nynz_o
);

  gnca_pkg::cfg_t cfg_q;
  logic [NNW-1:0] nynz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cells       <= {gnca_pkg::NUM_AXES{gnca_pkg::GRID_RESET}};
      cfg_q.half        <= {gnca_pkg::NUM_AXES{gnca_pkg::HALF_RESET}};
      cfg_q.recip_voxel <= gnca_pkg::RECIP_RESET;
      cfg_q.recip_sim   <= gnca_pkg::RECIP_RESET;
    end else if (wr_valid_i) begin
      case (gnca_pkg::cfg_reg_e'(wr_index_i))
        gnca_pkg::REG_GRID_CELLS_X:    cfg_q.cells[0] <= wr_data_i[gnca_pkg::GRID_W-1:0];
        gnca_pkg::REG_GRID_CELLS_Y:    cfg_q.cells[1] <= wr_data_i[gnca_pkg::GRID_W-1:0];
        gnca_pkg::REG_GRID_CELLS_Z:    cfg_q.cells[2] <= wr_data_i[gnca_pkg::GRID_W-1:0];
        gnca_pkg::REG_HALF_EXTENT_X:   cfg_q.half[0]  <= wr_data_i[gnca_pkg::HALF_W-1:0];
        gnca_pkg::REG_HALF_EXTENT_Y:   cfg_q.half[1]  <= wr_data_i[gnca_pkg::HALF_W-1:0];
        gnca_pkg::REG_HALF_EXTENT_Z:   cfg_q.half[2]  <= wr_data_i[gnca_pkg::HALF_W-1:0];
        gnca_pkg::REG_RECIP_VOXEL:     cfg_q.recip_voxel <= wr_data_i[gnca_pkg::RECIP_W-1:0];
        gnca_pkg::REG_RECIP_SIM_SCALE: cfg_q.recip_sim   <= wr_data_i[gnca_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes beyond the supported maximum are treated as the maximum.
  always_comb begin
    for (int a = 0; a < gnca_pkg::NUM_AXES; a++) begin
      if (32'(cfg_q.cells[a]) > 32'(MAX_CELLS_PER_AXIS)) begin
        cells_eff_o[a] = NW'(MAX_CELLS_PER_AXIS);
      end else begin
        cells_eff_o[a] = NW'(cfg_q.cells[a]);
      end
    end
  end

  // Registered plane size; the user must write only while idle, unchecked here.
  always_ff @(posedge clk_i) begin
    nynz_q <= NNW'(cells_eff_o[1]) * NNW'(cells_eff_o[2]);
  end

  assign cfg_o  = cfg_q;
  assign nynz_o = nynz_q;

endmodule

// File: rtl/gnca_coord_pipe.sv
// Nine-stage pipeline from position to clamped cell coordinates, neighbor ranges and start index.
module gnca_coord_pipe #(
  parameter int unsigned MAX_CELLS_PER_AXIS = gnca_pkg::MAX_CELLS_PER_AXIS,
  parameter int unsigned FRACTION_BITS      = gnca_pkg::FRACTION_BITS,
  localparam int unsigned NW  = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned NNW = 2 * NW
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                in_valid_i,
  output logic                                                in_ready_o,
  input  logic                                                in_kind_i,
  input  logic [gnca_pkg::NUM_AXES-1:0][gnca_pkg::POS_W-1:0]  in_pos_i,
  input  gnca_pkg::cfg_t                                      cfg_i,
  input  logic [gnca_pkg::NUM_AXES-1:0][NW-1:0]               cells_eff_i,
  input  logic [NNW-1:0]                                      nynz_i,
  output logic                                                out_valid_o,
  input  logic                                                out_ready_i,
  output gnca_pkg::walk_req_t                                 out_req_o
);

  localparam int unsigned NA   = gnca_pkg::NUM_AXES;
  localparam int unsigned NSTG = 9;
  // The kind is last needed by the stage that picks the neighbor slots.
  localparam int unsigned KSTG = 7;
  localparam int unsigned CW   = NW + 2;   // coordinate clamped to -2 .. MAX+1, two's complement
  localparam int unsigned IW   = gnca_pkg::IDX_W;
  localparam int unsigned PW   = (3 * NW > IW) ? 3 * NW : IW;
  localparam logic [CW-1:0] COORD_NEG2 = {{(CW-1){1'b1}}, 1'b0};

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] adv;
  logic [KSTG-1:0] kind_q;

  // Each stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) kind_q[0] <= in_kind_i;
    for (int k = 1; k < KSTG; k++) begin
      if (adv[k]) kind_q[k] <= kind_q[k-1];
    end
  end

  // Stage payloads, one lane per axis.
  logic [31:0]        pos1_q  [NA];
  logic [31:0]        mag1_q  [NA];
  logic               neg1_q  [NA];
  logic [31:0]        pos2_q  [NA];
  logic [63:0]        prod2_q [NA];
  logic               neg2_q  [NA];
  logic [31:0]        p3_d    [NA];
  logic [31:0]        p3_q    [NA];
  logic [33:0]        s4_q    [NA];
  logic [31:0]        mag5_q  [NA];
  logic               neg5_q  [NA];
  logic [63:0]        prod6_q [NA];
  logic               neg6_q  [NA];
  logic [CW-1:0]      c7_d    [NA];
  logic [CW-1:0]      c7_q    [NA];
  logic [1:0]         lo8_d   [NA];
  logic [1:0]         hi8_d   [NA];
  logic [NW-1:0]      sx8_d   [NA];
  logic [1:0]         lo8_q   [NA];
  logic [1:0]         hi8_q   [NA];
  logic [NW-1:0]      sx8_q   [NA];
  logic               empty8_d;
  logic               empty8_q;
  gnca_pkg::walk_req_t req9_d;
  gnca_pkg::walk_req_t req9_q;

  // Stages 1 and 2: magnitude, then the home-cell scaling product.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      if (adv[0]) begin
        pos1_q[a] <= in_pos_i[a];
        neg1_q[a] <= in_pos_i[a][31];
        mag1_q[a] <= in_pos_i[a][31] ? 32'(32'd0 - in_pos_i[a]) : in_pos_i[a];
      end
      if (adv[1]) begin
        pos2_q[a]  <= pos1_q[a];
        neg2_q[a]  <= neg1_q[a];
        prod2_q[a] <= 64'(mag1_q[a]) * 64'(cfg_i.recip_sim);
      end
    end
  end

  // Stage 3: drop the fraction, saturate to 32 bits signed, choose scaled or raw position.
  always_comb begin
    logic [63:0] q;
    q = '0;
    for (int a = 0; a < NA; a++) begin
      q = prod2_q[a] >> FRACTION_BITS;
      if (neg2_q[a]) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        p3_d[a] = 32'(64'd0 - q);
      end else begin
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        p3_d[a] = q[31:0];
      end
      if (!kind_q[1]) p3_d[a] = pos2_q[a];
    end
  end

  // Stages 3 to 6: offset by half the extent, magnitude, product with the reciprocal voxel size.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      if (adv[2]) p3_q[a] <= p3_d[a];
      if (adv[3]) s4_q[a] <= {{2{p3_q[a][31]}}, p3_q[a]} + {3'b000, cfg_i.half[a]};
      if (adv[4]) begin
        neg5_q[a] <= s4_q[a][33];
        mag5_q[a] <= s4_q[a][33] ? 32'(34'd0 - s4_q[a]) : s4_q[a][31:0];
      end
      if (adv[5]) begin
        neg6_q[a]  <= neg5_q[a];
        prod6_q[a] <= 64'(mag5_q[a]) * 64'(cfg_i.recip_voxel);
      end
    end
  end

  // Stage 7: integer cell coordinate, clamped so that bounds results are unchanged.
  always_comb begin
    logic [63:0] t;
    t = '0;
    for (int a = 0; a < NA; a++) begin
      t = prod6_q[a] >> (2 * FRACTION_BITS);
      if (neg6_q[a]) begin
        if (t >= 64'd2)      c7_d[a] = COORD_NEG2;
        else if (t == 64'd0) c7_d[a] = '0;
        else                 c7_d[a] = '1;
      end else begin
        if (t > 64'(MAX_CELLS_PER_AXIS + 1)) c7_d[a] = CW'(MAX_CELLS_PER_AXIS + 1);
        else                                 c7_d[a] = CW'(t);
      end
    end
  end

  // Stage 8: which of the three neighbor slots per axis are in bounds, and where the walk starts.
  always_comb begin
    logic [2:0]    m;
    logic [CW-1:0] xc;
    logic [CW-1:0] sxt;
    m        = '0;
    xc       = '0;
    sxt      = '0;
    empty8_d = 1'b0;
    for (int a = 0; a < NA; a++) begin
      for (int d = 0; d < 3; d++) begin
        xc   = c7_q[a] + CW'(d - 1);
        m[d] = !xc[CW-1] && (xc[CW-2:0] < {1'b0, cells_eff_i[a]});
      end
      // A home-cell query only looks at the center slot.
      if (kind_q[6]) m = m & 3'b010;
      case (m)
        3'b001:  begin lo8_d[a] = 2'd0; hi8_d[a] = 2'd0; end
        3'b010:  begin lo8_d[a] = 2'd1; hi8_d[a] = 2'd1; end
        3'b100:  begin lo8_d[a] = 2'd2; hi8_d[a] = 2'd2; end
        3'b011:  begin lo8_d[a] = 2'd0; hi8_d[a] = 2'd1; end
        3'b110:  begin lo8_d[a] = 2'd1; hi8_d[a] = 2'd2; end
        3'b111:  begin lo8_d[a] = 2'd0; hi8_d[a] = 2'd2; end
        default: begin lo8_d[a] = 2'd0; hi8_d[a] = 2'd0; end
      endcase
      if (m == 3'b000) empty8_d = 1'b1;
      sxt      = c7_q[a] + CW'(lo8_d[a]) - CW'(1);
      sx8_d[a] = sxt[NW-1:0];
    end
  end

  // Stage 9: row-major index of the first cell, kept modulo the index width.
  always_comb begin
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    px = PW'(sx8_q[0]) * PW'(nynz_i);
    py = PW'(sx8_q[1]) * PW'(cells_eff_i[2]);
    for (int a = 0; a < NA; a++) begin
      req9_d.lo[a] = lo8_q[a];
      req9_d.hi[a] = hi8_q[a];
    end
    req9_d.empty = empty8_q;
    req9_d.start = IW'(px) + IW'(py) + IW'(sx8_q[2]);
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      if (adv[6]) c7_q[a] <= c7_d[a];
      if (adv[7]) begin
        lo8_q[a] <= lo8_d[a];
        hi8_q[a] <= hi8_d[a];
        sx8_q[a] <= sx8_d[a];
      end
    end
    if (adv[7]) empty8_q <= empty8_d;
    if (adv[8]) req9_q   <= req9_d;
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_req_o   = req9_q;

endmodule

// File: rtl/gnca_nbr_walker.sv
// Neighbor walker: steps through the in-bounds cells of one request into a result register.
module gnca_nbr_walker #(
  parameter int unsigned MAX_CELLS_PER_AXIS = gnca_pkg::MAX_CELLS_PER_AXIS,
  localparam int unsigned NW  = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned NNW = 2 * NW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  gnca_pkg::walk_req_t           req_i,
  input  logic [NW-1:0]                 nz_i,
  input  logic [NNW-1:0]                nynz_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gnca_pkg::IDX_W-1:0]    out_index_o,
  output logic                          out_in_bounds_o,
  output logic                          out_last_o
);

  localparam int unsigned IW = gnca_pkg::IDX_W;

  logic                busy_q;
  logic                ovalid_q;
  gnca_pkg::walk_req_t req_q;
  logic [1:0]          i_q, j_q, k_q;
  logic [IW-1:0]       rowx_q, rowy_q, cur_q;
  logic [IW-1:0]       oindex_q;
  logic                oinb_q, olast_q;

  logic          last;
  logic          out_adv;
  logic          emit;
  logic          load;
  logic [IW-1:0] nz_ext;
  logic [IW-1:0] nynz_ext;

  assign nz_ext   = IW'(nz_i);
  assign nynz_ext = IW'(nynz_i);

  assign last    = req_q.empty ||
                   (i_q == req_q.hi[0] && j_q == req_q.hi[1] && k_q == req_q.hi[2]);
  assign out_adv = !ovalid_q || out_ready_i;
  assign emit    = busy_q && out_adv;
  // The next request loads in the cycle the current one issues its last result.
  assign req_ready_o = !busy_q || (emit && last);
  assign load        = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (load)              busy_q <= 1'b1;
      else if (emit && last) busy_q <= 1'b0;
      if (out_adv) ovalid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q  <= req_i;
      i_q    <= req_i.lo[0];
      j_q    <= req_i.lo[1];
      k_q    <= req_i.lo[2];
      rowx_q <= req_i.start;
      rowy_q <= req_i.start;
      cur_q  <= req_i.start;
    end else if (emit && !last) begin
      if (k_q != req_q.hi[2]) begin
        k_q   <= k_q + 2'd1;
        cur_q <= cur_q + IW'(1);
      end else if (j_q != req_q.hi[1]) begin
        j_q    <= j_q + 2'd1;
        k_q    <= req_q.lo[2];
        rowy_q <= rowy_q + nz_ext;
        cur_q  <= rowy_q + nz_ext;
      end else begin
        i_q    <= i_q + 2'd1;
        j_q    <= req_q.lo[1];
        k_q    <= req_q.lo[2];
        rowx_q <= rowx_q + nynz_ext;
        rowy_q <= rowx_q + nynz_ext;
        cur_q  <= rowx_q + nynz_ext;
      end
    end
    if (emit) begin
      oindex_q <= req_q.empty ? '0 : cur_q;
      oinb_q   <= !req_q.empty;
      olast_q  <= last;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_index_o     = oindex_q;
  assign out_in_bounds_o = oinb_q;
  assign out_last_o      = olast_q;

  a_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !oinb_q |-> olast_q)
    else $error("out-of-bounds result not marked last");

  a_load_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q)
    else $error("accepted request did not start a walk");

  a_slots_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_q.empty |->
      (i_q >= req_q.lo[0] && i_q <= req_q.hi[0] &&
       j_q >= req_q.lo[1] && j_q <= req_q.hi[1] &&
       k_q >= req_q.lo[2] && k_q <= req_q.hi[2]))
    else $error("walk position left its neighbor range");

  a_index_tracks_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_q.empty |-> (cur_q - rowy_q) == IW'(k_q - req_q.lo[2]))
    else $error("cell index out of step with z position");

endmodule
